[hdl/recsb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// recsb_pkg
// Shared constants and types for the range equal count block.
// ----------------------------------------------------------------------------
package recsb_pkg;

   localparam int SIZE_DEF       = 1024;
   localparam int BLOCK_SIZE_DEF = 32;

   localparam int PW          = 10;   // index field width
   localparam int VW          = 32;   // value width
   localparam int CNT_W       = 11;   // match count width
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 16;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      SM_WRITE = 2'd0,   // lower bound of old value, write path
      SM_UPPER = 2'd1,   // upper bound of query value
      SM_LOWER = 2'd2    // lower bound of query value
   } srch_mode_type;

   typedef struct packed {
      logic          start;
      logic [PW-1:0] num;
   } mod_req_type;

   typedef struct packed {
      logic          done;
      logic [PW-1:0] rem;
   } mod_rsp_type;

endpackage
`default_nettype wire

[hdl/recsb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// recsb_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module recsb_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hdl/recsb_mod.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// recsb_mod
// Remainder unit: num % BLOCK_SIZE by reciprocal multiply, result registered
// and valid in the cycle after start.
// ----------------------------------------------------------------------------
module recsb_mod import recsb_pkg::*; #(
   parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mod_req_type req,
   output mod_rsp_type      rsp
);

   // m = ceil(2^(PW+l) / BLOCK_SIZE), l = ceil(log2(BLOCK_SIZE)); exact
   // quotient for every PW-bit numerator
   localparam int SH = PW + $clog2(BLOCK_SIZE);
   localparam int MW = PW + 2;
   localparam logic [MW-1:0] RECIP =
      MW'(((64'd1 << SH) + 64'(BLOCK_SIZE) - 64'd1) / 64'(BLOCK_SIZE));
   localparam logic [PW-1:0] BS_C = PW'(BLOCK_SIZE);

   logic [PW+MW-1:0] prod;
   logic [PW-1:0]    quot;
   logic [2*PW-1:0]  back;
   logic             done_ff, done_in;
   logic [PW-1:0]    rem_ff, rem_in;

   always_comb begin
      prod    = (PW+MW)'(req.num) * (PW+MW)'(RECIP);
      quot    = PW'(prod >> SH);
      back    = (2*PW)'(quot) * (2*PW)'(BS_C);
      done_in = req.start;
      rem_in  = req.start ? (req.num - PW'(back)) : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;

endmodule
`default_nettype wire

[hdl/range_equal_count_sqrt_blocks.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// range_equal_count_sqrt_blocks
// Range equal-value counter over SIZE entries, sqrt-decomposed into blocks.
// ----------------------------------------------------------------------------
// Sequence: a write reads the old value, finds it in the block's sorted copy
//   by binary search and shifts the new value into order; a query checks
//   partial-block entries one by one and counts whole blocks by bound searches.
// Throughput: one item at a time; the single read port of each RAM sets it.
// Reset: synchronous; a clearing pass zeroes every entry of both RAMs and
//   req_tready stays low until it ends.
// ----------------------------------------------------------------------------
module range_equal_count_sqrt_blocks import recsb_pkg::*; #(
   parameter int SIZE       = SIZE_DEF,
   parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // position[9:0], item_value[41:10], range_low[51:42], range_high[61:52]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // opcode
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // match_count[10:0]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   localparam int IDX_W = $clog2(SIZE);
   localparam int CW    = ((IDX_W > PW) ? IDX_W : PW) + 2;
   localparam logic [CW-1:0] SIZE_C = CW'(SIZE);
   localparam logic [CW-1:0] BS_C   = CW'(BLOCK_SIZE);

   typedef enum logic [13:0] {
      S_CLEAR    = 14'b00000000000001,
      S_IDLE     = 14'b00000000000010,
      S_DIV      = 14'b00000000000100,
      S_WOLD_RD  = 14'b00000000001000,
      S_WOLD_WT  = 14'b00000000010000,
      S_SRCH_RD  = 14'b00000000100000,
      S_SRCH_WT  = 14'b00000001000000,
      S_LEFT_RD  = 14'b00000010000000,
      S_LEFT_WT  = 14'b00000100000000,
      S_RIGHT_RD = 14'b00001000000000,
      S_RIGHT_WT = 14'b00010000000000,
      S_QSTEP    = 14'b00100000000000,
      S_QENT_WT  = 14'b01000000000000,
      S_OUT      = 14'b10000000000000
   } state_type;

   // request fields
   logic                 in_op;
   logic [PW-1:0]        in_pos, in_lo, in_hi;
   logic signed [VW-1:0] in_val;
   logic                 req_acc;

   assign in_op   = req_tuser;
   assign in_pos  = req_tdata[9:0];
   assign in_val  = req_tdata[41:10];
   assign in_lo   = req_tdata[51:42];
   assign in_hi   = req_tdata[61:52];
   assign req_acc = req_tvalid && req_tready;

   // sequencer state
   state_type            state_ff, state_in;
   logic                 op_ff, op_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic signed [VW-1:0] val_ff, val_in;
   logic signed [VW-1:0] key_ff, key_in;
   logic [CW-1:0]        q_lo_ff, q_lo_in, q_hi_ff, q_hi_in, q_off_ff, q_off_in;
   logic [CW-1:0]        lo_ff, lo_in, hi_ff, hi_in, ub_ff, ub_in;
   logic [CW-1:0]        k_ff, k_in, start_ff, start_in, end_ff, end_in;
   logic                 moved_ff, moved_in;
   srch_mode_type        mode_ff, mode_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CW-1:0]        clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;

   // RAM ports
   logic                 ent_we, srt_we;
   logic [IDX_W-1:0]     ent_wa, ent_ra, srt_wa, srt_ra;
   logic [VW-1:0]        ent_wd, srt_wd, ent_rd, srt_rd;

   mod_req_type          mod_req;
   mod_rsp_type          mod_rsp;

   logic [CW-1:0]        mid, blk_start, blk_top;
   logic signed [VW-1:0] srch_x, srch_key;
   logic                 go_right;

   assign mid       = CW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign srch_x    = srt_rd;
   assign srch_key  = (mode_ff == SM_WRITE) ? key_ff : val_ff;
   assign go_right  = (mode_ff == SM_UPPER) ? (srch_x <= srch_key) : (srch_x < srch_key);
   assign blk_start = pos_ff - CW'(mod_rsp.rem);
   assign blk_top   = blk_start + BS_C;

   assign mod_req.start = req_acc;
   assign mod_req.num   = (in_op == OP_QUERY) ? in_lo : in_pos;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      key_in       = key_ff;
      q_lo_in      = q_lo_ff;
      q_hi_in      = q_hi_ff;
      q_off_in     = q_off_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      ub_in        = ub_ff;
      k_in         = k_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      moved_in     = moved_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      ent_we = 1'b0;
      ent_wa = pos_ff[IDX_W-1:0];
      ent_wd = val_ff;
      ent_ra = pos_ff[IDX_W-1:0];
      srt_we = 1'b0;
      srt_wa = k_ff[IDX_W-1:0];
      srt_wd = val_ff;
      srt_ra = mid[IDX_W-1:0];

      case (state_ff)
         S_CLEAR: begin
            ent_we = 1'b1;
            ent_wa = clr_ff[IDX_W-1:0];
            ent_wd = '0;
            srt_we = 1'b1;
            srt_wa = clr_ff[IDX_W-1:0];
            srt_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SIZE_C - 1'b1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               op_in    = in_op;
               pos_in   = CW'(in_pos);
               val_in   = in_val;
               q_lo_in  = CW'(in_lo);
               q_hi_in  = (CW'(in_hi) >= SIZE_C) ? SIZE_C - 1'b1 : CW'(in_hi);
               count_in = '0;
               // writes past the end are dropped
               if (in_op == OP_QUERY || CW'(in_pos) < SIZE_C) begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (mod_rsp.done) begin
               if (op_ff == OP_QUERY) begin
                  q_off_in = CW'(mod_rsp.rem);
                  state_in = S_QSTEP;
               end else begin
                  start_in = blk_start;
                  end_in   = (blk_top > SIZE_C) ? SIZE_C : blk_top;
                  state_in = S_WOLD_RD;
               end
            end
         end
         S_WOLD_RD: begin
            ent_ra   = pos_ff[IDX_W-1:0];
            state_in = S_WOLD_WT;
         end
         S_WOLD_WT: begin
            key_in   = ent_rd;
            ent_we   = 1'b1;
            lo_in    = start_ff;
            hi_in    = end_ff;
            mode_in  = SM_WRITE;
            state_in = S_SRCH_RD;
         end
         S_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               srt_ra   = mid[IDX_W-1:0];
               state_in = S_SRCH_WT;
            end else begin
               case (mode_ff)
                  SM_WRITE: begin
                     k_in     = (lo_ff >= end_ff) ? end_ff - 1'b1 : lo_ff;
                     moved_in = 1'b0;
                     state_in = S_LEFT_RD;
                  end
                  SM_UPPER: begin
                     ub_in   = lo_ff;
                     lo_in   = q_lo_ff;
                     hi_in   = q_lo_ff + BS_C;
                     mode_in = SM_LOWER;
                  end
                  default: begin
                     count_in = count_ff + CNT_W'(ub_ff - lo_ff);
                     q_lo_in  = q_lo_ff + BS_C;
                     state_in = S_QSTEP;
                  end
               endcase
            end
         end
         S_SRCH_WT: begin
            if (go_right) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
            state_in = S_SRCH_RD;
         end
         S_LEFT_RD: begin
            if (k_ff > start_ff) begin
               srt_ra   = IDX_W'(k_ff - 1'b1);
               state_in = S_LEFT_WT;
            end else if (moved_ff) begin
               srt_we   = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_RIGHT_RD;
            end
         end
         S_LEFT_WT: begin
            if ($signed(srt_rd) > val_ff) begin
               // shift larger neighbor right, new value slides left
               srt_we   = 1'b1;
               srt_wd   = srt_rd;
               k_in     = k_ff - 1'b1;
               moved_in = 1'b1;
               state_in = S_LEFT_RD;
            end else if (moved_ff) begin
               srt_we   = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_RIGHT_RD;
            end
         end
         S_RIGHT_RD: begin
            if (k_ff + 1'b1 < end_ff) begin
               srt_ra   = IDX_W'(k_ff + 1'b1);
               state_in = S_RIGHT_WT;
            end else begin
               srt_we   = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RIGHT_WT: begin
            srt_we = 1'b1;
            if (val_ff > $signed(srt_rd)) begin
               srt_wd   = srt_rd;
               k_in     = k_ff + 1'b1;
               state_in = S_RIGHT_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_QSTEP: begin
            if (q_lo_ff > q_hi_ff) begin
               state_in = S_OUT;
            end else if (q_off_ff == '0 && q_lo_ff + BS_C - 1'b1 <= q_hi_ff) begin
               // whole block: upper bound minus lower bound
               lo_in    = q_lo_ff;
               hi_in    = q_lo_ff + BS_C;
               mode_in  = SM_UPPER;
               state_in = S_SRCH_RD;
            end else begin
               ent_ra   = q_lo_ff[IDX_W-1:0];
               state_in = S_QENT_WT;
            end
         end
         S_QENT_WT: begin
            if ($signed(ent_rd) == val_ff) begin
               count_in = count_ff + 1'b1;
            end
            q_lo_in  = q_lo_ff + 1'b1;
            q_off_in = (q_off_ff == BS_C - 1'b1) ? '0 : q_off_ff + 1'b1;
            state_in = S_QSTEP;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      key_ff       <= key_in;
      q_lo_ff      <= q_lo_in;
      q_hi_ff      <= q_hi_in;
      q_off_ff     <= q_off_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      ub_ff        <= ub_in;
      k_ff         <= k_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      moved_ff     <= moved_in;
      mode_ff      <= mode_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

   // entry values in index order
   recsb_ram #(.DEPTH(SIZE), .WIDTH(VW)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_wa),
      .wr_data (ent_wd),
      .rd_addr (ent_ra),
      .rd_data (ent_rd)
   );

   // per-block sorted copy
   recsb_ram #(.DEPTH(SIZE), .WIDTH(VW)) u_sorted_ram (
      .clock   (clock),
      .wr_en   (srt_we),
      .wr_addr (srt_wa),
      .wr_data (srt_wd),
      .rd_addr (srt_ra),
      .rd_data (srt_rd)
   );

   recsb_mod #(.BLOCK_SIZE(BLOCK_SIZE)) u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .rsp   (mod_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_count_ff);

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready)
      else $error("item accepted during clearing pass");

   a_srch_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH_WT) |-> (lo_ff < hi_ff && hi_ff <= SIZE_C))
      else $error("search window empty or past end");

   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LEFT_WT) |-> (k_ff > start_ff))
      else $error("left shift past block start");

   a_right_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RIGHT_WT) |-> (k_ff + 1'b1 < end_ff))
      else $error("right shift past block end");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && mod_rsp.done) |-> (mod_rsp.rem < PW'(BLOCK_SIZE)))
      else $error("block offset out of range");

endmodule
`default_nettype wire
